FILE: hw/rtl/dtq_pkg.sv
// ----------------------------------------------------------------------------
// dtq_pkg: shared types and constants of the delayed event timer queue
// Field widths, command and result codes, entry layout and control states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package dtq_pkg;

   // default table depth
   localparam int QUEUE_DEPTH_DEF = 16;

   // field widths
   localparam int MODE_W    = 2;
   localparam int TYPE_W    = 32;
   localparam int RECV_W    = 16;
   localparam int PAYLOAD_W = 32;
   localparam int DELAY_W   = 32;
   localparam int STEP_W    = 31;
   localparam int KIND_W    = 3;
   localparam int ENTRY_W   = TYPE_W + RECV_W + PAYLOAD_W + DELAY_W;

   // command codes
   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_TICK   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

   // result codes
   localparam logic [KIND_W-1:0] KIND_INSERTED   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_DROPPED    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_FIRED      = 3'd2;
   localparam logic [KIND_W-1:0] KIND_NONE_FIRED = 3'd3;
   localparam logic [KIND_W-1:0] KIND_CLEARED    = 3'd4;

   // control states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_TICK,
      ST_FINISH
   } state_type;

   // one table entry as stored in memory
   typedef struct packed {
      logic [TYPE_W-1:0]    ev_type;
      logic [RECV_W-1:0]    receiver;
      logic [PAYLOAD_W-1:0] payload;
      logic [DELAY_W-1:0]   remaining;
   } entry_type;

   // outcome of one delay update
   typedef struct packed {
      logic               fire;
      logic [DELAY_W-1:0] remaining;
   } eval_type;

endpackage
`default_nettype wire

FILE: hw/rtl/delayed_event_timer_queue_core.sv
// ----------------------------------------------------------------------------
// delayed_event_timer_queue_core: table of pending timed events
// Insert, tick and clear commands over a memory-held event table.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel takes one command beat: insert (append an event at the
//   tail, dropped when the table is full), tick (age every event by
//   req_time_step and fire the due ones) or clear. The rsp_ channel returns
//   the result beats; rsp_last_result marks the final beat of a command.
//   Mode 3 is swallowed without a result.
//   Insert and clear give one beat each. A tick walks the table through
//   the single read port of the entry memory, one entry per cycle unless a
//   receiver stall holds it.
//   Survivors are compacted in place through the write port behind the read
//   pointer. Commands are handled one at a time.
//   A result register parts the channels: a new command is taken while a
//   beat waits, provided the register frees up in that cycle. When the
//   receiver stalls, the walk pauses on the next due event.
//   Reset empties the table at once; no clearing pass is needed since only
//   entries below the count are ever read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module delayed_event_timer_queue_core #(
   parameter int QUEUE_DEPTH = dtq_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [dtq_pkg::MODE_W-1:0]      req_mode,
   input  wire logic [dtq_pkg::TYPE_W-1:0]      req_event_type,
   input  wire logic [dtq_pkg::RECV_W-1:0]      req_receiver_id,
   input  wire logic [dtq_pkg::PAYLOAD_W-1:0]   req_payload_tag,
   input  wire logic signed [dtq_pkg::DELAY_W-1:0] req_delay_amount,
   input  wire logic [dtq_pkg::STEP_W-1:0]      req_time_step,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic      [dtq_pkg::KIND_W-1:0]      rsp_kind,
   output logic      [dtq_pkg::TYPE_W-1:0]      rsp_fired_type,
   output logic      [dtq_pkg::RECV_W-1:0]      rsp_fired_receiver,
   output logic      [dtq_pkg::PAYLOAD_W-1:0]   rsp_fired_payload,
   output logic                                 rsp_last_result
);
   import dtq_pkg::*;

   localparam int IW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

   // control state
   state_type            state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        rd_idx_ff, rd_idx_in;
   logic [CW-1:0]        keep_ff, keep_in;
   logic                 eval_valid_ff, eval_valid_in;
   logic                 held_valid_ff, held_valid_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [TYPE_W-1:0]    held_type_ff, held_type_in;
   logic [RECV_W-1:0]    held_recv_ff, held_recv_in;
   logic [PAYLOAD_W-1:0] held_payload_ff, held_payload_in;
   logic [KIND_W-1:0]    rsp_kind_ff, rsp_kind_in;
   logic [TYPE_W-1:0]    rsp_type_ff, rsp_type_in;
   logic [RECV_W-1:0]    rsp_recv_ff, rsp_recv_in;
   logic [PAYLOAD_W-1:0] rsp_payload_ff, rsp_payload_in;
   logic                 rsp_last_ff, rsp_last_in;

   // memory ports
   logic                 wr_en;
   logic [IW-1:0]        wr_addr;
   entry_type            wr_entry;
   logic                 rd_en;
   entry_type            rd_entry;
   logic [ENTRY_W-1:0]   rd_word;

   // walk control
   eval_type             ev;
   logic                 slot_free;
   logic                 req_beat;
   logic                 fire;
   logic                 stall;
   logic                 more;

   dtq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_idx_ff[IW-1:0]),
      .rd_data (rd_word)
   );

   assign rd_entry = entry_type'(rd_word);

   dtq_delay_eval u_delay_eval (
      .remaining (rd_entry.remaining),
      .time_step (step_ff),
      .result    (ev)
   );

   // handshake and walk conditions
   assign slot_free = ~rsp_valid_ff | rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) & slot_free;
   assign req_beat  = req_valid & req_ready;
   assign fire      = eval_valid_ff & ev.fire;
   assign stall     = fire & held_valid_ff & ~slot_free;
   assign more      = rd_idx_ff < count_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_beat && req_mode == MODE_TICK) begin
               state_in = ST_TICK;
            end
         end
         ST_TICK: begin
            if (!stall && !more) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and control outputs
   always_comb begin
      count_in        = count_ff;
      rd_idx_in       = rd_idx_ff;
      keep_in         = keep_ff;
      eval_valid_in   = eval_valid_ff;
      held_valid_in   = held_valid_ff;
      step_in         = step_ff;
      held_type_in    = held_type_ff;
      held_recv_in    = held_recv_ff;
      held_payload_in = held_payload_ff;
      rsp_valid_in    = rsp_valid_ff & ~rsp_ready;
      rsp_kind_in     = rsp_kind_ff;
      rsp_type_in     = rsp_type_ff;
      rsp_recv_in     = rsp_recv_ff;
      rsp_payload_in  = rsp_payload_ff;
      rsp_last_in     = rsp_last_ff;
      wr_en           = 1'b0;
      wr_addr         = keep_ff[IW-1:0];
      wr_entry        = '{ev_type: rd_entry.ev_type, receiver: rd_entry.receiver,
                          payload: rd_entry.payload, remaining: ev.remaining};
      rd_en           = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               rsp_type_in    = '0;
               rsp_recv_in    = '0;
               rsp_payload_in = '0;
               rsp_last_in    = 1'b1;
               case (req_mode)
                  MODE_INSERT: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff < DEPTH_C) begin
                        // append at the tail
                        wr_en       = 1'b1;
                        wr_addr     = count_ff[IW-1:0];
                        wr_entry    = '{ev_type: req_event_type, receiver: req_receiver_id,
                                        payload: req_payload_tag,
                                        remaining: req_delay_amount};
                        count_in    = count_ff + 1'b1;
                        rsp_kind_in = KIND_INSERTED;
                     end else begin
                        rsp_kind_in = KIND_DROPPED;
                     end
                  end
                  MODE_TICK: begin
                     // start the walk
                     step_in       = req_time_step;
                     rd_idx_in     = '0;
                     keep_in       = '0;
                     eval_valid_in = 1'b0;
                     held_valid_in = 1'b0;
                  end
                  MODE_CLEAR: begin
                     count_in     = '0;
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = KIND_CLEARED;
                  end
                  default: ;
               endcase
            end
         end
         ST_TICK: begin
            if (!stall) begin
               // retire the entry in the eval stage
               if (eval_valid_ff) begin
                  if (ev.fire) begin
                     if (held_valid_ff) begin
                        rsp_valid_in   = 1'b1;
                        rsp_kind_in    = KIND_FIRED;
                        rsp_type_in    = held_type_ff;
                        rsp_recv_in    = held_recv_ff;
                        rsp_payload_in = held_payload_ff;
                        rsp_last_in    = 1'b0;
                     end
                     held_valid_in   = 1'b1;
                     held_type_in    = rd_entry.ev_type;
                     held_recv_in    = rd_entry.receiver;
                     held_payload_in = rd_entry.payload;
                  end else begin
                     // compact survivor behind the read pointer
                     wr_en   = 1'b1;
                     keep_in = keep_ff + 1'b1;
                  end
               end
               // advance the read pointer
               rd_en         = more;
               eval_valid_in = more;
               if (more) begin
                  rd_idx_in = rd_idx_ff + 1'b1;
               end
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_last_in   = 1'b1;
               count_in      = keep_ff;
               held_valid_in = 1'b0;
               if (held_valid_ff) begin
                  rsp_kind_in    = KIND_FIRED;
                  rsp_type_in    = held_type_ff;
                  rsp_recv_in    = held_recv_ff;
                  rsp_payload_in = held_payload_ff;
               end else begin
                  rsp_kind_in    = KIND_NONE_FIRED;
                  rsp_type_in    = '0;
                  rsp_recv_in    = '0;
                  rsp_payload_in = '0;
               end
            end
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         rd_idx_ff     <= '0;
         keep_ff       <= '0;
         eval_valid_ff <= 1'b0;
         held_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rd_idx_ff     <= rd_idx_in;
         keep_ff       <= keep_in;
         eval_valid_ff <= eval_valid_in;
         held_valid_ff <= held_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      step_ff         <= step_in;
      held_type_ff    <= held_type_in;
      held_recv_ff    <= held_recv_in;
      held_payload_ff <= held_payload_in;
      rsp_kind_ff     <= rsp_kind_in;
      rsp_type_ff     <= rsp_type_in;
      rsp_recv_ff     <= rsp_recv_in;
      rsp_payload_ff  <= rsp_payload_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_kind_ff;
   assign rsp_fired_type     = rsp_type_ff;
   assign rsp_fired_receiver = rsp_recv_ff;
   assign rsp_fired_payload  = rsp_payload_ff;
   assign rsp_last_result    = rsp_last_ff;

   // table never overfills
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("entry count above depth");

   // compaction writes stay behind the read pointer
   a_keep_behind : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TICK) |-> (keep_ff <= rd_idx_ff && rd_idx_ff <= count_ff))
      else $error("compaction pointer overtook read pointer");

   // no held event survives a finished tick
   a_held_idle : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !held_valid_ff)
      else $error("fired event left behind after tick");

   // a finished tick always ends in a final beat
   a_finish_last : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && slot_free) |=> (rsp_valid_ff && rsp_last_ff))
      else $error("tick ended without final beat");

endmodule
`default_nettype wire

FILE: hw/rtl/dtq_ram.sv
// ----------------------------------------------------------------------------
// dtq_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module dtq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read; data holds while rd_en is low
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

FILE: hw/rtl/dtq_delay_eval.sv
// ----------------------------------------------------------------------------
// dtq_delay_eval: delay update for one entry
// Subtract the time step at full width, saturate at the negative limit and
// flag the entry as due when the new delay is at or below zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module dtq_delay_eval (
   input  wire logic     [dtq_pkg::DELAY_W-1:0] remaining,
   input  wire logic     [dtq_pkg::STEP_W-1:0]  time_step,
   output dtq_pkg::eval_type                    result
);
   import dtq_pkg::*;

   logic [DELAY_W:0] diff;
   logic             underflow;

   // exact difference, one guard bit
   assign diff = {remaining[DELAY_W-1], remaining}
               - {{(DELAY_W + 1 - STEP_W){1'b0}}, time_step};

   // below the most negative value: sign set, next bit clear
   assign underflow = diff[DELAY_W] & ~diff[DELAY_W-1];

   always_comb begin
      result.remaining = underflow ? {1'b1, {(DELAY_W - 1){1'b0}}} : diff[DELAY_W-1:0];
      result.fire      = diff[DELAY_W] | (diff == '0);
   end

endmodule
`default_nettype wire

FILE: tb/delayed_event_timer_queue_core_test.sv
// ----------------------------------------------------------------------------
// delayed_event_timer_queue_core_test: self-checking bench of the timer queue
// Drives insert, tick, clear and unused commands into the req_ channel and
// compares every rsp_ beat against a behavioral copy of the event table.
// Covers field extremes, a full table, ticks that fire nothing or everything,
// random traffic with idle bursts on both sides, and a final burst with none.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module delayed_event_timer_queue_core_test;
   import dtq_pkg::*;

   localparam int                DEPTH        = QUEUE_DEPTH_DEF;
   localparam logic [MODE_W-1:0] MODE_UNUSED  = 2'd3;
   localparam int                QUIET_LIMIT  = 2000;
   localparam int                DRAIN_CYCLES = DEPTH + 8;

   typedef struct {
      logic [MODE_W-1:0]           mode;
      logic [TYPE_W-1:0]           ev_type;
      logic [RECV_W-1:0]           receiver;
      logic [PAYLOAD_W-1:0]        payload;
      logic signed [DELAY_W-1:0]   delay;
      logic [STEP_W-1:0]           step;
   } command_type;

   typedef struct {
      logic [KIND_W-1:0]    kind;
      logic [TYPE_W-1:0]    ev_type;
      logic [RECV_W-1:0]    receiver;
      logic [PAYLOAD_W-1:0] payload;
      logic                 last;
   } outcome_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // block ports
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic [MODE_W-1:0]             req_mode = MODE_INSERT;
   logic [TYPE_W-1:0]             req_event_type = '0;
   logic [RECV_W-1:0]             req_receiver_id = '0;
   logic [PAYLOAD_W-1:0]          req_payload_tag = '0;
   logic signed [DELAY_W-1:0]     req_delay_amount = '0;
   logic [STEP_W-1:0]             req_time_step = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [KIND_W-1:0]             rsp_kind;
   logic [TYPE_W-1:0]             rsp_fired_type;
   logic [RECV_W-1:0]             rsp_fired_receiver;
   logic [PAYLOAD_W-1:0]          rsp_fired_payload;
   logic                          rsp_last_result;

   delayed_event_timer_queue_core #(
      .QUEUE_DEPTH(DEPTH)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_mode(req_mode),
      .req_event_type(req_event_type),
      .req_receiver_id(req_receiver_id),
      .req_payload_tag(req_payload_tag),
      .req_delay_amount(req_delay_amount),
      .req_time_step(req_time_step),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_kind(rsp_kind),
      .rsp_fired_type(rsp_fired_type),
      .rsp_fired_receiver(rsp_fired_receiver),
      .rsp_fired_payload(rsp_fired_payload),
      .rsp_last_result(rsp_last_result)
   );

   // shadow event table
   logic [TYPE_W-1:0]           shadow_type[DEPTH];
   logic [RECV_W-1:0]           shadow_receiver[DEPTH];
   logic [PAYLOAD_W-1:0]        shadow_payload[DEPTH];
   logic signed [DELAY_W-1:0]   shadow_delay[DEPTH];
   int                          shadow_count = 0;

   outcome_type predicted_results[$];

   bit allow_idle = 1'b1;
   int fail_count = 0;
   int commands_sent = 0;
   int beats_checked = 0;
   int events_fired = 0;
   int inserts_dropped = 0;
   int stall_left = 0;
   int quiet_cycles = 0;

   // outcome beat builder
   function automatic outcome_type outcome(input logic [KIND_W-1:0] kind,
                                           input logic [TYPE_W-1:0] ev_type,
                                           input logic [RECV_W-1:0] receiver,
                                           input logic [PAYLOAD_W-1:0] payload,
                                           input logic last);
      outcome_type o;
      o.kind = kind;
      o.ev_type = ev_type;
      o.receiver = receiver;
      o.payload = payload;
      o.last = last;
      return o;
   endfunction

   // append one predicted beat behind the older ones
   function automatic void queue_beat(input outcome_type o);
      predicted_results.insert(predicted_results.size(), o);
   endfunction

   // apply one accepted command to the shadow table and queue its beats
   function automatic void predict_table_outcome(input command_type c);
      longint aged;
      int     kept;
      int     fired;
      case (c.mode)
         MODE_INSERT: begin
            if (shadow_count >= DEPTH) begin
               queue_beat(outcome(KIND_DROPPED, '0, '0, '0, 1'b1));
               inserts_dropped++;
            end else begin
               shadow_type[shadow_count] = c.ev_type;
               shadow_receiver[shadow_count] = c.receiver;
               shadow_payload[shadow_count] = c.payload;
               shadow_delay[shadow_count] = c.delay;
               shadow_count++;
               queue_beat(outcome(KIND_INSERTED, '0, '0, '0, 1'b1));
            end
         end
         MODE_TICK: begin
            kept = 0;
            fired = 0;
            for (int i = 0; i < shadow_count; i++) begin
               aged = longint'(shadow_delay[i]) - longint'({1'b0, c.step});
               // saturate at the negative limit
               if (aged < -64'sd2147483648)
                  aged = -64'sd2147483648;
               if (aged <= 0) begin
                  queue_beat(outcome(KIND_FIRED, shadow_type[i],
                     shadow_receiver[i], shadow_payload[i], 1'b0));
                  fired++;
               end else begin
                  // compact survivors, keeping queue order
                  shadow_type[kept] = shadow_type[i];
                  shadow_receiver[kept] = shadow_receiver[i];
                  shadow_payload[kept] = shadow_payload[i];
                  shadow_delay[kept] = aged[DELAY_W-1:0];
                  kept++;
               end
            end
            shadow_count = kept;
            events_fired += fired;
            if (fired == 0)
               queue_beat(outcome(KIND_NONE_FIRED, '0, '0, '0, 1'b1));
            else
               predicted_results[predicted_results.size() - 1].last = 1'b1;
         end
         MODE_CLEAR: begin
            shadow_count = 0;
            queue_beat(outcome(KIND_CLEARED, '0, '0, '0, 1'b1));
         end
         default: begin
            // unused mode: swallowed without a beat
         end
      endcase
   endfunction

   // command builders; fields a command ignores carry random bits
   function automatic command_type random_command(input logic [MODE_W-1:0] mode);
      command_type c;
      c.mode = mode;
      c.ev_type = $urandom;
      c.receiver = RECV_W'($urandom);
      c.payload = $urandom;
      c.delay = $urandom;
      c.step = STEP_W'($urandom);
      return c;
   endfunction

   function automatic command_type insert_cmd(input logic [TYPE_W-1:0] ev_type,
                                              input logic [RECV_W-1:0] receiver,
                                              input logic [PAYLOAD_W-1:0] payload,
                                              input logic signed [DELAY_W-1:0] delay);
      command_type c;
      c = random_command(MODE_INSERT);
      c.ev_type = ev_type;
      c.receiver = receiver;
      c.payload = payload;
      c.delay = delay;
      return c;
   endfunction

   function automatic command_type tick_cmd(input logic [STEP_W-1:0] step);
      command_type c;
      c = random_command(MODE_TICK);
      c.step = step;
      return c;
   endfunction

   // mostly short delays so ticks fire a few at a time; sometimes full range
   function automatic logic signed [DELAY_W-1:0] random_delay();
      if ($urandom_range(0, 4) == 0)
         return $urandom;
      return $signed($urandom_range(0, 32'h0006_0000)) - 32'sh0000_8000;
   endfunction

   function automatic logic [STEP_W-1:0] random_step();
      if ($urandom_range(0, 9) == 0)
         return STEP_W'($urandom);
      return STEP_W'($urandom_range(0, 32'h0002_0000));
   endfunction

   // send one command beat; valid stays up between back-to-back beats
   task automatic send_command(input command_type c);
      int gap;
      if (allow_idle && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 15);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= c.mode;
      req_event_type <= c.ev_type;
      req_receiver_id <= c.receiver;
      req_payload_tag <= c.payload;
      req_delay_amount <= c.delay;
      req_time_step <= c.step;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_table_outcome(c);
      commands_sent++;
   endtask

   // hold the sender until every predicted beat has come back
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (predicted_results.size() != 0);
   endtask

   // receiver: random stall bursts while idling is allowed
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (allow_idle && $urandom_range(0, 5) == 0) begin
         rsp_ready <= 1'b0;
         stall_left <= $urandom_range(0, 14);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // check each result beat against the oldest prediction
   always @(posedge clock) begin : check_results
      outcome_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (predicted_results.size() == 0) begin
            $error("unexpected result beat: kind %0d", rsp_kind);
            fail_count++;
         end else begin
            want = predicted_results.pop_front();
            beats_checked++;
            if (rsp_kind !== want.kind) begin
               $error("kind: expected %0d, got %0d", want.kind, rsp_kind);
               fail_count++;
            end
            if (rsp_fired_type !== want.ev_type) begin
               $error("fired_type: expected %h, got %h", want.ev_type, rsp_fired_type);
               fail_count++;
            end
            if (rsp_fired_receiver !== want.receiver) begin
               $error("fired_receiver: expected %h, got %h", want.receiver,
                      rsp_fired_receiver);
               fail_count++;
            end
            if (rsp_fired_payload !== want.payload) begin
               $error("fired_payload: expected %h, got %h", want.payload,
                      rsp_fired_payload);
               fail_count++;
            end
            if (rsp_last_result !== want.last) begin
               $error("last_result: expected %b, got %b", want.last, rsp_last_result);
               fail_count++;
            end
         end
      end
   end

   // watchdog: give up after a long run of cycles with no beat on either side
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog expired with %0d beats outstanding", predicted_results.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // extremes of every field, saturation, unused mode, fire-nothing ticks
   task automatic test_field_extremes();
      send_command(tick_cmd('0));
      send_command(insert_cmd('1, '1, '1, 32'sh7FFF_FFFF));
      send_command(insert_cmd('0, '0, '0, 32'sh8000_0000));
      send_command(insert_cmd(32'hA5A5_5A5A, '0, 32'h5A5A_A5A5, 32'sh0000_0000));
      send_command(insert_cmd(32'h0000_0001, 16'h8001, 32'h8000_0000, 32'sh0000_0001));
      send_command(insert_cmd(32'h8000_0000, 16'h0001, 32'h0000_0001, -32'sd1));
      send_command(random_command(MODE_UNUSED));
      send_command(tick_cmd('0));
      send_command(tick_cmd(31'd1));
      send_command(tick_cmd(31'h7FFF_FFFE));
      send_command(insert_cmd(32'h1234_5678, 16'hFFFE, 32'h8765_4321, 32'sh8000_0000));
      send_command(tick_cmd(31'h7FFF_FFFF));
      send_command(random_command(MODE_CLEAR));
   endtask

   // fill the table, overflow it, then fire every entry in one tick
   task automatic test_full_table();
      for (int i = 0; i < DEPTH; i++)
         send_command(insert_cmd($urandom, RECV_W'($urandom), $urandom,
                                 $urandom_range(1, 32'h7FFF_FFFF)));
      send_command(insert_cmd($urandom, RECV_W'($urandom), $urandom, random_delay()));
      send_command(tick_cmd(31'h7FFF_FFFF));
      send_command(tick_cmd(random_step()));
      for (int i = 0; i < 4; i++)
         send_command(insert_cmd($urandom, RECV_W'($urandom), $urandom, random_delay()));
      send_command(random_command(MODE_CLEAR));
   endtask

   // weighted random traffic; mostly inserts and ticks, a little noise
   task automatic run_random_traffic(input int count, input int pause_at);
      int pick;
      for (int n = 0; n < count; n++) begin
         if (n == pause_at)
            wait_for_drain();
         pick = $urandom_range(0, 99);
         if (pick < 55)
            send_command(insert_cmd($urandom, RECV_W'($urandom), $urandom,
                                    random_delay()));
         else if (pick < 90)
            send_command(tick_cmd(random_step()));
         else if (pick < 95)
            send_command(random_command(MODE_CLEAR));
         else
            send_command(random_command(MODE_UNUSED));
      end
   endtask

   task automatic test_random_with_idling();
      allow_idle = 1'b1;
      run_random_traffic(180, 90);
   endtask

   task automatic test_back_to_back();
      allow_idle = 1'b0;
      run_random_traffic(50, -1);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_field_extremes();
      test_full_table();
      test_random_with_idling();
      test_back_to_back();

      // drain and let any late beat show up
      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d commands, %0d result beats checked", commands_sent, beats_checked);
      $display("events fired: %0d, inserts dropped on a full table: %0d",
               events_fired, inserts_dropped);
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

FILE: delayed_event_timer_queue_core.f
hw/rtl/dtq_pkg.sv
hw/rtl/dtq_ram.sv
hw/rtl/dtq_delay_eval.sv
hw/rtl/delayed_event_timer_queue_core.sv
tb/delayed_event_timer_queue_core_test.sv
